>>> hdl/spq_pkg.sv
package spq_pkg;

  // Default number of entry cells
  localparam int DEF_CAPACITY = 16;

  // Request codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SEARCH = 2'd3
  } spq_cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } spq_status_t;

  // Shared compare unit modes
  typedef enum logic {
    CMP_PRI_LT = 1'b0,
    CMP_VAL_EQ = 1'b1
  } spq_cmp_mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_SRCH
  } spq_state_t;

  typedef struct packed {
    spq_cmd_t           cmd;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } spq_req_t;

  typedef struct packed {
    spq_status_t        status;
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [4:0]         count;
  } spq_res_t;

  // One stored cell
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } spq_entry_t;

  function automatic spq_res_t mk_res(spq_status_t st, logic signed [31:0] v,
                                      logic signed [15:0] p);
    spq_res_t r;
    r.status       = st;
    r.out_value    = v;
    r.out_priority = p;
    r.count        = 5'd0;
    return r;
  endfunction

endpackage

>>> hdl/spq_store.sv
module spq_store #(
  parameter int DEPTH = spq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  spq_pkg::spq_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output spq_pkg::spq_entry_t rdata
);
  import spq_pkg::*;

  spq_entry_t mem [DEPTH];
  spq_entry_t rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/spq_cmp.sv
module spq_cmp (
  input  spq_pkg::spq_cmp_mode_t mode,
  input  logic signed [31:0]     a,
  input  logic signed [31:0]     b,
  output logic                   hit
);
  import spq_pkg::*;

  // Priority mode: a < b (signed); value mode: a == b
  always_comb begin
    unique case (mode)
      CMP_PRI_LT: hit = (a < b);
      CMP_VAL_EQ: hit = (a == b);
      default:    hit = 1'b0;
    endcase
  end

endmodule

>>> hdl/spq_seq.sv
module spq_seq #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  spq_pkg::spq_req_t      in_req,
  output logic                   out_strobe,
  output spq_pkg::spq_res_t      out_res,
  // store
  output logic                   mem_we,
  output logic [IW-1:0]          mem_waddr,
  output spq_pkg::spq_entry_t    mem_wdata,
  output logic [IW-1:0]          mem_raddr,
  input  spq_pkg::spq_entry_t    mem_rdata,
  // shared compare unit
  output spq_pkg::spq_cmp_mode_t cmp_mode,
  output logic signed [31:0]     cmp_a,
  output logic signed [31:0]     cmp_b,
  input  logic                   cmp_hit
);
  import spq_pkg::*;

  spq_state_t    state_r, state_nxt;
  spq_req_t      req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  spq_res_t      res_r, res_nxt;
  logic          strobe_r, strobe_nxt;
  logic          last;
  spq_entry_t    new_ent;

  assign new_ent.value = req_r.item_value;
  assign new_ent.prio  = req_r.item_priority;
  // current index is the tail entry
  assign last = (CW'(idx_r) == count_r - CW'(1));

  // State and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_r;
    cmp_mode   = CMP_PRI_LT;
    cmp_a      = {{16{mem_rdata.prio[15]}}, mem_rdata.prio};
    cmp_b      = {{16{req_r.item_priority[15]}}, req_r.item_priority};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          unique case (in_req.cmd)
            CMD_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                res_nxt    = mk_res(ST_FULL, '0, '0);
                strobe_nxt = 1'b1;
              end else if (count_r == '0) begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.value = in_req.item_value;
                mem_wdata.prio  = in_req.item_priority;
                count_nxt       = CW'(1);
                res_nxt         = mk_res(ST_OK, '0, '0);
                strobe_nxt      = 1'b1;
              end else begin
                // walk from the tail toward the head
                mem_raddr = IW'(count_r - CW'(1));
                idx_nxt   = IW'(count_r - CW'(1));
                state_nxt = S_INS_CMP;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_nxt    = mk_res(ST_EMPTY, '0, '0);
                strobe_nxt = 1'b1;
              end else begin
                mem_raddr = '0;
                state_nxt = S_POP_HEAD;
              end
            end
            CMD_CLEAR: begin
              count_nxt  = '0;
              res_nxt    = mk_res(ST_OK, '0, '0);
              strobe_nxt = 1'b1;
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                res_nxt    = mk_res(ST_NOTFOUND, '0, '0);
                strobe_nxt = 1'b1;
              end else begin
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end

      // entry idx is in mem_rdata; lower priority moves down one slot
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + IW'(1);
        if (cmp_hit) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            mem_raddr = idx_r - IW'(1);
            idx_nxt   = idx_r - IW'(1);
          end
        end else begin
          mem_wdata  = new_ent;
          count_nxt  = count_r + CW'(1);
          res_nxt    = mk_res(ST_OK, '0, '0);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // new entry becomes the head
      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = new_ent;
        count_nxt  = count_r + CW'(1);
        res_nxt    = mk_res(ST_OK, '0, '0);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      // capture the head, then shift the rest up
      S_POP_HEAD: begin
        res_nxt = mk_res(ST_OK, mem_rdata.value, mem_rdata.prio);
        if (count_r == CW'(1)) begin
          count_nxt  = '0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_raddr = IW'(1);
          idx_nxt   = IW'(1);
          state_nxt = S_POP_SHIFT;
        end
      end

      S_POP_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - IW'(1);
        mem_wdata = mem_rdata;
        if (last) begin
          count_nxt  = count_r - CW'(1);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_raddr = idx_r + IW'(1);
          idx_nxt   = idx_r + IW'(1);
        end
      end

      // first match from the head wins
      S_SRCH: begin
        cmp_mode = CMP_VAL_EQ;
        cmp_a    = mem_rdata.value;
        cmp_b    = req_r.item_value;
        if (cmp_hit) begin
          res_nxt    = mk_res(ST_OK, '0, mem_rdata.prio);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (last) begin
          res_nxt    = mk_res(ST_NOTFOUND, '0, '0);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_raddr = idx_r + IW'(1);
          idx_nxt   = idx_r + IW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // count after this request
    if (strobe_nxt) begin
      res_nxt.count = 5'(count_nxt);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request neither in progress nor answered");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.status == ST_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("full reported while space left");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |-> !mem_we)
    else $error("store written while idle");
`endif

endmodule

>>> hdl/sorted_priority_queue_top.sv
// Sorted priority queue: holds up to CAPACITY (value, priority) entries in
// priority order, highest first, arrival order kept among equal priorities.
// Request channel: in_req carries cmd, item_value, item_priority; a request
// is taken at a rising edge with start high and busy low.
// Result channel: out_strobe is high for one cycle with out_res (status,
// out_value, out_priority, count); there is no way to hold a result back.
// Clear, full insert, empty pop, empty search and insert into an empty
// queue are answered straight from idle. Any other insert walks from the
// tail toward the head, moving each lower-priority entry down one slot;
// pop reads the head, then shifts the rest up; search scans from the head
// (index 0) to the first match or the tail.
// At most one entry is read and one written per cycle through the entry
// store's read and write ports, and one shared comparator decides each
// step, so the walk length sets the rate. busy is low again in the strobe
// cycle, so the next request may be given then.
// Reset empties the queue; entry cells need no clearing.
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t in_req,
  output logic              out_strobe,
  output spq_pkg::spq_res_t out_res
);
  import spq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [IW-1:0]      mem_raddr;
  spq_entry_t         mem_wdata;
  spq_entry_t         mem_rdata;
  spq_cmp_mode_t      cmp_mode;
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_b;
  logic               cmp_hit;

  // Sequencer
  spq_seq #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .CW      (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_mode  (cmp_mode),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_hit   (cmp_hit)
  );

  // Entry store
  spq_store #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Shared comparator
  spq_cmp u_cmp (
    .mode(cmp_mode),
    .a   (cmp_a),
    .b   (cmp_b),
    .hit (cmp_hit)
  );

endmodule

>>> test/tb_sorted_priority_queue_top.sv
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int QCAP = DEF_CAPACITY;
  localparam int RAND_REQS = 1150;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  spq_req_t in_req = '0;
  logic out_strobe;
  spq_res_t out_res;

  sorted_priority_queue_top #(
    .CAPACITY(QCAP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_strobe(out_strobe),
    .out_res(out_res)
  );

  // Directed request rows; want is used only when fixed is set
  typedef struct {
    spq_req_t req;
    bit       fixed;
    spq_res_t want;
  } stim_row_t;

  stim_row_t stim_rows[$];
  spq_res_t pending_res[$];
  int errors = 0;
  int idle_pct = 0;
  bit filling = 1'b1;

  // Shadow copy of the queue contents, head at index 0
  logic signed [31:0] held_val [QCAP];
  logic signed [15:0] held_pri [QCAP];
  int held = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Apply one request to the shadow queue and return its result
  function automatic spq_res_t apply_request(spq_req_t r);
    spq_res_t res;
    int pos;
    res = '0;
    res.status = ST_OK;
    case (r.cmd)
      CMD_INSERT: begin
        if (held >= QCAP) begin
          res.status = ST_FULL;
        end else begin
          // goes behind every entry of equal or higher priority
          pos = held;
          for (int i = held - 1; i >= 0; i--)
            if (held_pri[i] < r.item_priority) pos = i;
          for (int i = held; i > pos; i--) begin
            held_val[i] = held_val[i-1];
            held_pri[i] = held_pri[i-1];
          end
          held_val[pos] = r.item_value;
          held_pri[pos] = r.item_priority;
          held++;
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_value = held_val[0];
          res.out_priority = held_pri[0];
          for (int i = 1; i < held; i++) begin
            held_val[i-1] = held_val[i];
            held_pri[i-1] = held_pri[i];
          end
          held--;
        end
      end
      CMD_CLEAR: held = 0;
      CMD_SEARCH: begin
        // scan from the tail so the match nearest the head wins
        res.status = ST_NOTFOUND;
        for (int i = held - 1; i >= 0; i--)
          if (held_val[i] == r.item_value) begin
            res.status = ST_OK;
            res.out_priority = held_pri[i];
          end
      end
    endcase
    res.count = held[4:0];
    return res;
  endfunction

  // Random request: fill toward full, then drain toward empty, with noise
  function automatic spq_req_t next_random_request();
    spq_req_t r;
    int roll;
    r.item_value = $urandom;
    r.item_priority = 16'($urandom);
    if (filling && held == QCAP && $urandom_range(2) == 0) filling = 1'b0;
    if (!filling && held == 0 && $urandom_range(1) == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (filling)
      r.cmd = (roll < 65) ? CMD_INSERT : (roll < 82) ? CMD_SEARCH :
              (roll < 99) ? CMD_POP : CMD_CLEAR;
    else
      r.cmd = (roll < 60) ? CMD_POP : (roll < 84) ? CMD_SEARCH :
              (roll < 99) ? CMD_INSERT : CMD_CLEAR;
    case (r.cmd)
      CMD_INSERT: begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: r.item_value = $urandom_range(15);
          8: r.item_value = 32'sh7FFFFFFF;
          9: r.item_value = 32'sh80000000;
          default: ;
        endcase
        // narrow priorities give plenty of ties
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            r.item_priority = 16'($urandom_range(8));
            r.item_priority = r.item_priority - 16'sd4;
          end
          8: r.item_priority = 16'sh7FFF;
          9: r.item_priority = 16'sh8000;
          default: ;
        endcase
      end
      CMD_SEARCH: begin
        if (held > 0 && $urandom_range(2) != 0)
          r.item_value = held_val[$urandom_range(held - 1)];
        else if ($urandom_range(1) == 0)
          r.item_value = $urandom_range(15);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(spq_cmd_t c, logic signed [31:0] v, logic signed [15:0] p,
                         bit fixed, spq_res_t want);
    stim_row_t row;
    row.req.cmd = c;
    row.req.item_value = v;
    row.req.item_priority = p;
    row.fixed = fixed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  // Present one request, wait for it to be taken, record its expected result
  task automatic issue_request(spq_req_t r, bit fixed, spq_res_t want);
    spq_res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    pred = apply_request(r);
    pending_res.push_back(fixed ? want : pred);
  endtask

  initial begin
    spq_res_t none;
    none = '0;

    // empty-queue corner cases
    add_row(CMD_POP,    32'sd0, 16'sd0, 1, '{ST_EMPTY, 32'sd0, 16'sd0, 5'd0});
    add_row(CMD_SEARCH, 32'sd0, 16'sd0, 1, '{ST_NOTFOUND, 32'sd0, 16'sd0, 5'd0});
    add_row(CMD_CLEAR,  32'sd0, 16'sd0, 1, '{ST_OK, 32'sd0, 16'sd0, 5'd0});
    // field extremes, ties and a duplicate value
    add_row(CMD_INSERT, 32'sh7FFFFFFF, 16'sh7FFF, 1, '{ST_OK, 32'sd0, 16'sd0, 5'd1});
    add_row(CMD_INSERT, 32'sh80000000, 16'sh8000, 1, '{ST_OK, 32'sd0, 16'sd0, 5'd2});
    add_row(CMD_INSERT, 32'sd5, 16'sd0, 0, none);
    add_row(CMD_INSERT, 32'sd6, 16'sd0, 0, none);
    add_row(CMD_INSERT, 32'sd5, -16'sd1, 0, none);
    add_row(CMD_SEARCH, 32'sd5, 16'sd0, 0, none);
    add_row(CMD_SEARCH, 32'sh80000000, 16'sd0, 1,
            '{ST_OK, 32'sd0, 16'sh8000, 5'd5});
    add_row(CMD_POP, 32'sd0, 16'sd0, 1, '{ST_OK, 32'sh7FFFFFFF, 16'sh7FFF, 5'd4});
    // fill up to capacity
    add_row(CMD_INSERT, 32'sd100, 16'sh7FFF, 0, none);
    add_row(CMD_INSERT, 32'sd101, 16'sh8000, 0, none);
    add_row(CMD_INSERT, 32'sd102, 16'sd0, 0, none);
    add_row(CMD_INSERT, 32'sd103, 16'sd0, 0, none);
    add_row(CMD_INSERT, 32'sd104, 16'sd1, 0, none);
    add_row(CMD_INSERT, -32'sd1, -16'sd1, 0, none);
    add_row(CMD_INSERT, 32'sd0, 16'sd16384, 0, none);
    add_row(CMD_INSERT, 32'sh55555555, -16'sd2, 0, none);
    add_row(CMD_INSERT, 32'shAAAAAAAA, 16'sd3, 0, none);
    add_row(CMD_INSERT, 32'sd107, 16'sh7FFF, 0, none);
    add_row(CMD_INSERT, 32'sd108, 16'sd0, 0, none);
    add_row(CMD_INSERT, 32'sd109, 16'sh8000, 0, none);
    // full queue: insert dropped, miss, then clear
    add_row(CMD_INSERT, 32'sd110, 16'sd5, 1, '{ST_FULL, 32'sd0, 16'sd0, 5'd16});
    add_row(CMD_SEARCH, 32'sd12345, 16'sd0, 1, '{ST_NOTFOUND, 32'sd0, 16'sd0, 5'd16});
    add_row(CMD_CLEAR, 32'sd0, 16'sd0, 1, '{ST_OK, 32'sd0, 16'sd0, 5'd0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 23;
    foreach (stim_rows[i])
      issue_request(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].want);

    // random requests in three idling phases
    for (int k = 0; k < RAND_REQS; k++) begin
      if (k == RAND_REQS / 3) idle_pct = 61;
      if (k == 2 * RAND_REQS / 3) idle_pct = 0;
      issue_request(next_random_request(), 0, none);
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending_res.size() != 0) @(posedge clk);
    repeat (QCAP + 4) @(posedge clk);

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Result checker
  always @(posedge clk) begin : check_results
    spq_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_res);
      end else begin
        want = pending_res.pop_front();
        if (out_res.status !== want.status || out_res.out_value !== want.out_value ||
            out_res.out_priority !== want.out_priority || out_res.count !== want.count)
        begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_res);
        end
      end
    end
  end

endmodule
